/* src/cpes_pkg.sv */
// Shared types, constants and the microcode table of the cart-pendulum Euler stepper.
// Used by cart_pendulum_euler_step, plant_state_checker and cart_pendulum_euler_step_tb; depends on nothing else.
package cpes_pkg;

    // Formats and widths
    localparam int FRAC_BITS_DEF      = 16;
    localparam int STEP_FRAC_BITS_DEF = 24;
    localparam int DATA_W             = 32;
    localparam int DT_W               = 24;
    localparam int PROD_W             = 2 * DATA_W;
    localparam int NUM_CFG            = 8;
    localparam int CFG_IDX_W          = $clog2(NUM_CFG);
    localparam int CFG_ADDR_W         = CFG_IDX_W + 1;
    localparam int STEP_W             = 4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_COEF_VEL_DAMP   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_VEL_ANGLE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_RATE_DAMP  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_RATE_ANGLE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_FORCE_VEL  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_FORCE_RATE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_POSITION   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_ANGLE      = 3'd7;

    // Multiplier A operand select
    localparam logic [2:0] A_VEL_DAMP   = 3'd0;
    localparam logic [2:0] A_VEL_ANGLE  = 3'd1;
    localparam logic [2:0] A_RATE_DAMP  = 3'd2;
    localparam logic [2:0] A_RATE_ANGLE = 3'd3;
    localparam logic [2:0] A_FORCE_VEL  = 3'd4;
    localparam logic [2:0] A_FORCE_RATE = 3'd5;
    localparam logic [2:0] A_STEP       = 3'd6;

    // Multiplier B operand select
    localparam logic [2:0] B_VEL   = 3'd0;
    localparam logic [2:0] B_ANG   = 3'd1;
    localparam logic [2:0] B_RATE  = 3'd2;
    localparam logic [2:0] B_FORCE = 3'd3;
    localparam logic [2:0] B_ACCV  = 3'd4;
    localparam logic [2:0] B_ACCR  = 3'd5;

    // Adder X operand select
    localparam logic [2:0] X_ZERO = 3'd0;
    localparam logic [2:0] X_ACC  = 3'd1;
    localparam logic [2:0] X_POS  = 3'd2;
    localparam logic [2:0] X_VEL  = 3'd3;
    localparam logic [2:0] X_ANG  = 3'd4;
    localparam logic [2:0] X_RATE = 3'd5;

    // Adder destination
    localparam logic [2:0] D_NONE = 3'd0;
    localparam logic [2:0] D_ACC  = 3'd1;
    localparam logic [2:0] D_ACCV = 3'd2;
    localparam logic [2:0] D_ACCR = 3'd3;
    localparam logic [2:0] D_POS  = 3'd4;
    localparam logic [2:0] D_VEL  = 3'd5;
    localparam logic [2:0] D_ANG  = 3'd6;
    localparam logic [2:0] D_RATE = 3'd7;

    // Jump conditions
    localparam logic [1:0] J_NONE    = 2'd0;
    localparam logic [1:0] J_RESTART = 2'd1;
    localparam logic [1:0] J_ALWAYS  = 2'd2;

    // Program addresses that are jump targets
    localparam logic [STEP_W-1:0] STEP_EMIT    = 4'd11;
    localparam logic [STEP_W-1:0] STEP_RESTART = 4'd12;

    typedef struct packed {
        logic [2:0]        mul_a;
        logic [2:0]        mul_b;
        logic [2:0]        add_x;
        logic [2:0]        add_dst;
        logic              load_init;
        logic [1:0]        jump_cond;
        logic [STEP_W-1:0] jump_to;
        logic              done;
    } ctl_word_t;

    // Microcode: the multiply issued in a step is accumulated in the next step.
    function automatic ctl_word_t ucode_rom(input logic [STEP_W-1:0] step);
        ctl_word_t w;
        w = '0;
        case (step)
            4'd0: begin
                w.mul_a = A_VEL_DAMP;   w.mul_b = B_VEL;
                w.jump_cond = J_RESTART; w.jump_to = STEP_RESTART;
            end
            4'd1: begin
                w.mul_a = A_VEL_ANGLE;  w.mul_b = B_ANG;
                w.add_x = X_ZERO;       w.add_dst = D_ACC;
            end
            4'd2: begin
                w.mul_a = A_FORCE_VEL;  w.mul_b = B_FORCE;
                w.add_x = X_ACC;        w.add_dst = D_ACC;
            end
            4'd3: begin
                w.mul_a = A_RATE_DAMP;  w.mul_b = B_VEL;
                w.add_x = X_ACC;        w.add_dst = D_ACCV;
            end
            4'd4: begin
                w.mul_a = A_RATE_ANGLE; w.mul_b = B_ANG;
                w.add_x = X_ZERO;       w.add_dst = D_ACC;
            end
            4'd5: begin
                w.mul_a = A_FORCE_RATE; w.mul_b = B_FORCE;
                w.add_x = X_ACC;        w.add_dst = D_ACC;
            end
            4'd6: begin
                w.mul_a = A_STEP;       w.mul_b = B_VEL;
                w.add_x = X_ACC;        w.add_dst = D_ACCR;
            end
            4'd7: begin
                w.mul_a = A_STEP;       w.mul_b = B_RATE;
                w.add_x = X_POS;        w.add_dst = D_POS;
            end
            4'd8: begin
                w.mul_a = A_STEP;       w.mul_b = B_ACCV;
                w.add_x = X_ANG;        w.add_dst = D_ANG;
            end
            4'd9: begin
                w.mul_a = A_STEP;       w.mul_b = B_ACCR;
                w.add_x = X_VEL;        w.add_dst = D_VEL;
            end
            4'd10: begin
                w.add_x = X_RATE;       w.add_dst = D_RATE;
            end
            4'd11: begin
                w.done = 1'b1;
            end
            4'd12: begin
                w.load_init = 1'b1;
                w.jump_cond = J_ALWAYS; w.jump_to = STEP_EMIT;
            end
            default: begin
                w.done = 1'b1;
            end
        endcase
        return w;
    endfunction

    // Clamp to the signed 32-bit range
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] x);
        logic signed [PROD_W-1:0] hi;
        logic signed [PROD_W-1:0] lo;
        hi = PROD_W'({1'b0, {(DATA_W-1){1'b1}}});
        lo = -hi - PROD_W'(1);
        if (x > hi) begin
            return {1'b0, {(DATA_W-1){1'b1}}};
        end else if (x < lo) begin
            return {1'b1, {(DATA_W-1){1'b0}}};
        end
        return x[DATA_W-1:0];
    endfunction

endpackage

/* src/cart_pendulum_euler_step.sv */
// Top level of the cart-pendulum forward-Euler stepper: microcode sequencer,
// shared 32x32 multiplier, accumulator and state. Depends on cpes_pkg.
//
// Usage:
//   Configuration: write the eight Q16.16 registers through cfg_wr_en /
//   cfg_addr / cfg_wr_data while the block is idle; indexes beyond 7 are
//   ignored. All registers and the plant state clear to zero at reset.
//   Input (s_*): one word per integration step: force and time step in
//   s_tdata, restart flag in s_tuser. A word is taken only while the block
//   is idle (s_tready high).
//   Output (m_*): one word holding the new position, velocity, angle and
//   rate. It is held in an output register until taken.
//   Sequencing: a step word runs microcode steps 0 to 11; a restart word
//   runs steps 0, 12 and 11. The next word is accepted in the cycle the
//   result appears; the block works on one word at a time, its pace set by the
//   ten products that share one multiplier. If the receiver stalls, the
//   following word is still taken and worked on, and it waits at its last
//   step until the output register frees.
//   Reset: aresetn is synchronous and active low; it clears config, state,
//   the sequencer and the output valid.
module cart_pendulum_euler_step #(
    parameter int FRAC_BITS      = cpes_pkg::FRAC_BITS_DEF,
    parameter int STEP_FRAC_BITS = cpes_pkg::STEP_FRAC_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration write port
    input  logic                            cfg_wr_en,
    input  logic [cpes_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [cpes_pkg::DATA_W-1:0]     cfg_wr_data,
    // input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [55:0]                     s_tdata,   // force_req[31:0], time_step[55:32]
    input  logic                            s_tuser,   // restart
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [127:0]                    m_tdata    // cart_position[31:0],
                                                       // cart_velocity[63:32],
                                                       // pendulum_angle[95:64],
                                                       // angular_rate[127:96]
);
    import cpes_pkg::*;

    // Configuration registers
    logic signed [DATA_W-1:0] cfg_reg [NUM_CFG];

    // Plant state and intermediate accelerations
    logic signed [DATA_W-1:0] pos_reg, vel_reg, ang_reg, rate_reg;
    logic signed [DATA_W-1:0] accv_reg, accr_reg;
    logic signed [PROD_W-1:0] acc_reg;

    // Latched input word
    logic signed [DATA_W-1:0] force_reg;
    logic [DT_W-1:0]          dt_reg;
    logic                     restart_reg;

    // Sequencer
    logic                     busy_reg;
    logic [STEP_W-1:0]        step_reg;
    logic [STEP_W-1:0]        step_next;
    ctl_word_t                ctl;
    logic                     jump_taken;
    logic                     stall;
    logic                     run;

    // Datapath
    logic signed [DATA_W-1:0] mul_a_op, mul_b_op;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     prod_dt_reg;
    logic signed [PROD_W-1:0] prod_shifted;
    logic signed [PROD_W-1:0] add_x_op;
    logic signed [PROD_W-1:0] sum;
    logic signed [DATA_W-1:0] sum_sat;

    // Output register
    logic                     m_tvalid_reg;
    logic [127:0]             m_tdata_reg;

    logic                     in_accept;

    assign in_accept = s_tvalid && s_tready;
    assign s_tready  = !busy_reg;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // Fetch the control word
    assign ctl = ucode_rom(step_reg);

    // Hold at the emit step while the output register is still full
    assign stall = ctl.done && m_tvalid_reg && !m_tready;
    assign run   = busy_reg && !stall;

    always_comb begin
        case (ctl.jump_cond)
            J_RESTART: jump_taken = restart_reg;
            J_ALWAYS:  jump_taken = 1'b1;
            default:   jump_taken = 1'b0;
        endcase
    end

    always_comb begin
        if (jump_taken) begin
            step_next = ctl.jump_to;
        end else begin
            step_next = step_reg + STEP_W'(1);
        end
    end

    // Select multiplier operands
    always_comb begin
        case (ctl.mul_a)
            A_VEL_DAMP:   mul_a_op = cfg_reg[REG_COEF_VEL_DAMP];
            A_VEL_ANGLE:  mul_a_op = cfg_reg[REG_COEF_VEL_ANGLE];
            A_RATE_DAMP:  mul_a_op = cfg_reg[REG_COEF_RATE_DAMP];
            A_RATE_ANGLE: mul_a_op = cfg_reg[REG_COEF_RATE_ANGLE];
            A_FORCE_VEL:  mul_a_op = cfg_reg[REG_GAIN_FORCE_VEL];
            A_FORCE_RATE: mul_a_op = cfg_reg[REG_GAIN_FORCE_RATE];
            A_STEP:       mul_a_op = {{(DATA_W-DT_W){1'b0}}, dt_reg};
            default:      mul_a_op = '0;
        endcase
    end

    always_comb begin
        case (ctl.mul_b)
            B_VEL:   mul_b_op = vel_reg;
            B_ANG:   mul_b_op = ang_reg;
            B_RATE:  mul_b_op = rate_reg;
            B_FORCE: mul_b_op = force_reg;
            B_ACCV:  mul_b_op = accv_reg;
            B_ACCR:  mul_b_op = accr_reg;
            default: mul_b_op = '0;
        endcase
    end

    // Floor-shift the registered product by its format
    assign prod_shifted = prod_dt_reg ? (prod_reg >>> STEP_FRAC_BITS)
                                      : (prod_reg >>> FRAC_BITS);

    always_comb begin
        case (ctl.add_x)
            X_ZERO:  add_x_op = '0;
            X_ACC:   add_x_op = acc_reg;
            X_POS:   add_x_op = PROD_W'(pos_reg);
            X_VEL:   add_x_op = PROD_W'(vel_reg);
            X_ANG:   add_x_op = PROD_W'(ang_reg);
            X_RATE:  add_x_op = PROD_W'(rate_reg);
            default: add_x_op = '0;
        endcase
    end

    assign sum     = add_x_op + prod_shifted;
    assign sum_sat = sat32(sum);

    // Write configuration registers; ignore out-of-range indexes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_CFG; i++) begin
                cfg_reg[i] <= '0;
            end
        end else if (cfg_wr_en && !cfg_addr[CFG_ADDR_W-1]) begin
            cfg_reg[cfg_addr[CFG_IDX_W-1:0]] <= cfg_wr_data;
        end
    end

    // Advance the sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end else if (in_accept) begin
            busy_reg <= 1'b1;
            step_reg <= '0;
        end else if (run) begin
            if (ctl.done) begin
                busy_reg <= 1'b0;
                step_reg <= '0;
            end else begin
                step_reg <= step_next;
            end
        end
    end

    // Latch the input word
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            force_reg   <= s_tdata[31:0];
            dt_reg      <= s_tdata[55:32];
            restart_reg <= s_tuser;
        end
    end

    // Multiply stage
    always_ff @(posedge aclk) begin
        if (run) begin
            prod_reg    <= mul_a_op * mul_b_op;
            prod_dt_reg <= (ctl.mul_a == A_STEP);
        end
    end

    // Accumulator and acceleration registers
    always_ff @(posedge aclk) begin
        if (run) begin
            case (ctl.add_dst)
                D_ACC:   acc_reg  <= sum;
                D_ACCV:  accv_reg <= sum_sat;
                D_ACCR:  accr_reg <= sum_sat;
                default: ;
            endcase
        end
    end

    // Plant state: in-place Euler update or restart load
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= '0;
            vel_reg  <= '0;
            ang_reg  <= '0;
            rate_reg <= '0;
        end else if (run) begin
            if (ctl.load_init) begin
                pos_reg  <= cfg_reg[REG_INIT_POSITION];
                vel_reg  <= '0;
                ang_reg  <= cfg_reg[REG_INIT_ANGLE];
                rate_reg <= '0;
            end else begin
                case (ctl.add_dst)
                    D_POS:   pos_reg  <= sum_sat;
                    D_VEL:   vel_reg  <= sum_sat;
                    D_ANG:   ang_reg  <= sum_sat;
                    D_RATE:  rate_reg <= sum_sat;
                    default: ;
                endcase
            end
        end
    end

    // Output register: load on emit, drop valid when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (run && ctl.done) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (run && ctl.done) begin
            m_tdata_reg <= {rate_reg, ang_reg, vel_reg, pos_reg};
        end
    end

endmodule

/* test/plant_state_checker.sv */
// Watches the configuration port and both streams of the cart-pendulum stepper, predicts each
// new plant state and compares it with the words that leave the block.
// Depends on cpes_pkg; instantiated by cart_pendulum_euler_step_tb.
module plant_state_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [cpes_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [cpes_pkg::DATA_W-1:0]     cfg_wr_data,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [55:0]                     s_tdata,   // force_req[31:0], time_step[55:32]
    input  logic                            s_tuser,   // restart
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [127:0]                    m_tdata,   // cart_position, cart_velocity,
                                                       // pendulum_angle, angular_rate
    output int                              mismatch_count,
    output int                              pending_states
);
    import cpes_pkg::*;

    localparam int     Q_FRAC   = FRAC_BITS_DEF;
    localparam int     DT_FRAC  = STEP_FRAC_BITS_DEF;
    localparam longint WORD_TOP = 64'sd2147483647;
    localparam longint WORD_BOT = -64'sd2147483648;

    // Highest field first, so the struct lines up with m_tdata
    typedef struct packed {
        logic signed [DATA_W-1:0] rate;
        logic signed [DATA_W-1:0] angle;
        logic signed [DATA_W-1:0] velocity;
        logic signed [DATA_W-1:0] position;
    } plant_state_t;

    logic signed [DATA_W-1:0] coef_regs [NUM_CFG];
    plant_state_t             plant;
    plant_state_t             expected_states [$];
    int                       fail_tally = 0;

    assign mismatch_count = fail_tally;

    function automatic logic signed [DATA_W-1:0] clamp_word(input longint x);
        if (x > WORD_TOP) begin
            return WORD_TOP[DATA_W-1:0];
        end else if (x < WORD_BOT) begin
            return WORD_BOT[DATA_W-1:0];
        end
        return x[DATA_W-1:0];
    endfunction

    // Exact product, floored back to the Q16.16 grid
    function automatic longint scale_q(input logic signed [DATA_W-1:0] a,
                                       input logic signed [DATA_W-1:0] b);
        longint p;
        p = longint'(a) * longint'(b);
        return p >>> Q_FRAC;
    endfunction

    // old + floor(dt * deriv), clamped
    function automatic logic signed [DATA_W-1:0] euler_term(
        input logic signed [DATA_W-1:0] old,
        input logic [DT_W-1:0]          dt,
        input logic signed [DATA_W-1:0] deriv
    );
        longint inc;
        inc = (longint'(dt) * longint'(deriv)) >>> DT_FRAC;
        return clamp_word(longint'(old) + inc);
    endfunction

    function automatic plant_state_t advance_plant(
        input plant_state_t             now,
        input logic                     restart,
        input logic signed [DATA_W-1:0] force_in,
        input logic [DT_W-1:0]          dt
    );
        plant_state_t             nxt;
        logic signed [DATA_W-1:0] acc_vel;
        logic signed [DATA_W-1:0] acc_rate;
        if (restart) begin
            nxt.position = coef_regs[REG_INIT_POSITION];
            nxt.velocity = '0;
            nxt.angle    = coef_regs[REG_INIT_ANGLE];
            nxt.rate     = '0;
            return nxt;
        end
        acc_vel  = clamp_word(scale_q(coef_regs[REG_COEF_VEL_DAMP], now.velocity) +
                              scale_q(coef_regs[REG_COEF_VEL_ANGLE], now.angle) +
                              scale_q(coef_regs[REG_GAIN_FORCE_VEL], force_in));
        acc_rate = clamp_word(scale_q(coef_regs[REG_COEF_RATE_DAMP], now.velocity) +
                              scale_q(coef_regs[REG_COEF_RATE_ANGLE], now.angle) +
                              scale_q(coef_regs[REG_GAIN_FORCE_RATE], force_in));
        nxt.position = euler_term(now.position, dt, now.velocity);
        nxt.velocity = euler_term(now.velocity, dt, acc_vel);
        nxt.angle    = euler_term(now.angle, dt, now.rate);
        nxt.rate     = euler_term(now.rate, dt, acc_rate);
        return nxt;
    endfunction

    function automatic int field_diff(input string name,
                                      input logic signed [DATA_W-1:0] want,
                                      input logic signed [DATA_W-1:0] got);
        if (want === got) begin
            return 0;
        end
        $display("%0t: %s mismatch: expected %0d (0x%08h), got %0d (0x%08h)",
                 $time, name, want, want, got, got);
        return 1;
    endfunction

    // Compare the outgoing word first: it can never belong to a word taken at the same edge
    always @(posedge aclk) begin
        plant_state_t got;
        plant_state_t want;
        int           errs;
        errs = 0;
        if (!aresetn) begin
            foreach (coef_regs[i]) begin
                coef_regs[i] = '0;
            end
            plant = '0;
            expected_states.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got = plant_state_t'(m_tdata);
                if (expected_states.size() == 0) begin
                    $display("%0t: unexpected result word: expected none, got 0x%032h",
                             $time, m_tdata);
                    errs = 1;
                end else begin
                    want = expected_states.pop_front();
                    errs += field_diff("cart_position", want.position, got.position);
                    errs += field_diff("cart_velocity", want.velocity, got.velocity);
                    errs += field_diff("pendulum_angle", want.angle, got.angle);
                    errs += field_diff("angular_rate", want.rate, got.rate);
                end
            end
            // Drop writes beyond the last register
            if (cfg_wr_en && cfg_addr < NUM_CFG) begin
                coef_regs[cfg_addr[CFG_IDX_W-1:0]] = cfg_wr_data;
            end
            if (s_tvalid && s_tready) begin
                plant = advance_plant(plant, s_tuser, s_tdata[31:0], s_tdata[55:32]);
                expected_states.push_back(plant);
            end
        end
        fail_tally     <= fail_tally + errs;
        pending_states <= expected_states.size();
    end

endmodule

/* test/cart_pendulum_euler_step_tb.sv */
// Top of the cart-pendulum stepper test: clock, reset, register settings, step words and
// random back-pressure. Depends on cpes_pkg, cart_pendulum_euler_step and plant_state_checker.
module cart_pendulum_euler_step_tb;
    import cpes_pkg::*;

    localparam logic [DATA_W-1:0] WORD_MAX  = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] WORD_MIN  = 32'h8000_0000;
    localparam logic [DATA_W-1:0] ONE_Q16   = 32'h0001_0000;
    localparam logic [DT_W-1:0]   DT_MAX    = 24'hFF_FFFF;
    localparam int                QUIET_MAX = 1000;
    localparam int                PHASES    = 5;
    localparam int                PHASE_LEN = 245;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [DATA_W-1:0]     cfg_wr_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [55:0]           s_tdata;   // force_req[31:0], time_step[55:32]
    logic                  s_tuser;   // restart
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [127:0]          m_tdata;   // cart_position[31:0], cart_velocity[63:32],
                                      // pendulum_angle[95:64], angular_rate[127:96]
    int                    mismatch_count;
    int                    pending_states;
    int                    rx_hold = 0;
    int                    quiet_cycles = 0;
    bit                    gaps_on = 1'b0;
    bit                    stalls_on = 1'b0;

    cart_pendulum_euler_step dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    plant_state_checker checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_addr       (cfg_addr),
        .cfg_wr_data    (cfg_wr_data),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .mismatch_count (mismatch_count),
        .pending_states (pending_states)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Mostly short pauses, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // Extremes, raw words, or small values that keep the plant from pinning at once
    function automatic logic [DATA_W-1:0] pick_param();
        case ($urandom_range(0, 9))
            0: begin
                return WORD_MAX;
            end
            1: begin
                return WORD_MIN;
            end
            2, 3: begin
                return $urandom();
            end
            default: begin
                return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
            end
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_force();
        case ($urandom_range(0, 9))
            0: begin
                return WORD_MAX;
            end
            1: begin
                return WORD_MIN;
            end
            2: begin
                return '0;
            end
            3, 4, 5: begin
                return $urandom();
            end
            default: begin
                return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
            end
        endcase
    endfunction

    function automatic logic [DT_W-1:0] pick_step();
        case ($urandom_range(0, 9))
            0: begin
                return '0;
            end
            1: begin
                return DT_MAX;
            end
            2, 3, 4: begin
                return DT_W'($urandom());
            end
            default: begin
                return DT_W'($urandom_range(0, 24'h01_0000));
            end
        endcase
    endfunction

    // Offer one word and hold it until the block takes it
    task automatic send_word(input logic restart, input logic [DATA_W-1:0] force_in,
                             input logic [DT_W-1:0] dt);
        int gap;
        gap = gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {dt, force_in};
        s_tuser  <= restart;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Lower valid and wait until every predicted state has come back
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_states != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [DATA_W-1:0] val);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
    endtask

    // Write all eight registers while idle, plus one write past the end that must be ignored
    task automatic load_setting(input logic [DATA_W-1:0] vel_damp, vel_angle,
                                rate_damp, rate_angle, force_vel, force_rate,
                                init_pos, init_ang);
        wait_drain();
        write_reg(CFG_ADDR_W'(REG_COEF_VEL_DAMP), vel_damp);
        write_reg(CFG_ADDR_W'(REG_COEF_VEL_ANGLE), vel_angle);
        write_reg(CFG_ADDR_W'(REG_COEF_RATE_DAMP), rate_damp);
        write_reg(CFG_ADDR_W'(REG_COEF_RATE_ANGLE), rate_angle);
        write_reg(CFG_ADDR_W'(REG_GAIN_FORCE_VEL), force_vel);
        write_reg(CFG_ADDR_W'(REG_GAIN_FORCE_RATE), force_rate);
        write_reg(CFG_ADDR_W'(REG_INIT_POSITION), init_pos);
        write_reg(CFG_ADDR_W'(REG_INIT_ANGLE), init_ang);
        write_reg(CFG_ADDR_W'(NUM_CFG) + CFG_ADDR_W'($urandom_range(0, NUM_CFG - 1)),
                  $urandom());
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // Receiver: random stalls while enabled, otherwise always ready
    always @(posedge aclk) begin
        if (rx_hold > 0) begin
            rx_hold  <= rx_hold - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (stalls_on) begin
                rx_hold <= pick_gap();
            end
        end
    end

    // Watchdog: end the run if no word moves on either stream for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_MAX) begin
            $display("FAIL cart_pendulum_euler_step");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_addr    <= '0;
        cfg_wr_data <= '0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tuser     <= 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: every coefficient zero, so nothing moves
        send_word(1'b0, WORD_MAX, DT_MAX);
        send_word(1'b1, WORD_MIN, DT_MAX);

        // Plausible plant: damping, unstable angle term, force gains, non-zero start
        load_setting(32'hFFFF_8000, 32'hFFFE_0000, 32'h0000_4000, 32'h0013_999A,
                     ONE_Q16, 32'hFFFE_8000, ONE_Q16, 32'h0000_199A);
        send_word(1'b1, '0, '0);
        send_word(1'b0, WORD_MAX, '0);             // zero step leaves the state alone
        send_word(1'b0, ONE_Q16, 24'h00_4189);     // about one millisecond
        send_word(1'b0, WORD_MIN, 24'd1);
        repeat (4) send_word(1'b0, WORD_MAX, DT_MAX);
        repeat (2) send_word(1'b0, WORD_MIN, DT_MAX);
        send_word(1'b1, $urandom(), DT_W'($urandom()));   // restart ignores force and step

        // Upper extremes: saturate every sum upwards
        load_setting(WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX,
                     WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX);
        send_word(1'b1, $urandom(), DT_W'($urandom()));
        repeat (2) send_word(1'b0, WORD_MAX, DT_MAX);
        send_word(1'b0, WORD_MIN, DT_MAX);

        // Lower extremes
        load_setting(WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN,
                     WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN);
        send_word(1'b1, $urandom(), DT_W'($urandom()));
        repeat (2) send_word(1'b0, WORD_MIN, DT_MAX);
        send_word(1'b0, WORD_MAX, DT_MAX);

        // Random phases: first with no idling, then sender gaps, receiver stalls, both
        for (int phase = 0; phase < PHASES; phase++) begin
            load_setting(pick_param(), pick_param(), pick_param(), pick_param(),
                         pick_param(), pick_param(), pick_param(), pick_param());
            gaps_on   = (phase == 1) || (phase >= 3);
            stalls_on = (phase >= 2);
            send_word(1'b1, $urandom(), DT_W'($urandom()));
            for (int n = 1; n < PHASE_LEN; n++) begin
                send_word($urandom_range(0, 24) == 0, pick_force(), pick_step());
            end
        end

        wait_drain();
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("PASS cart_pendulum_euler_step");
        end else begin
            $display("FAIL cart_pendulum_euler_step");
        end
        $finish;
    end

endmodule

/* sim.f */
src/cpes_pkg.sv
src/cart_pendulum_euler_step.sv
test/plant_state_checker.sv
test/cart_pendulum_euler_step_tb.sv
